// ===== hdl/mfe_pkg.sv =====
// Shared types, constants and the CRC fold for the MAVLink v1 frame encoder.
// No dependencies; every other file of the block imports this package.
package mfe_pkg;

   localparam logic [7:0]  START_MARKER = 8'hFE;
   localparam logic [15:0] CRC_SEED     = 16'hFFFF;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYSTEM_ID    = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMPONENT_ID = 8'd1;

   // one queued item, already classified by the front
   typedef struct packed {
      logic [7:0] payload_byte;
      logic [7:0] message_id;
      logic [7:0] payload_length;
      logic [7:0] msg_seed;
      logic [7:0] sequence_number;
      logic [7:0] system_id;
      logic [7:0] component_id;
      logic       header;    // first item of a frame: emit the header
      logic       has_pay;   // item carries a payload byte
      logic       ends;      // frame closes after this item
   } job_type;

   typedef enum logic [3:0] {
      ST_MARK,
      ST_LEN,
      ST_SEQ,
      ST_SYS,
      ST_COMP,
      ST_MID,
      ST_PAY,
      ST_CRCL,
      ST_CRCH
   } step_type;

   // X.25 / MCRF4XX byte fold
   function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
      logic [7:0] t;
      t = b ^ crc[7:0];
      t = t ^ {t[3:0], 4'h0};
      crc_fold = {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000}
               ^ {12'h000, t[7:4]};
   endfunction

endpackage

// ===== hdl/mfe_front.sv =====
// Front end: configuration registers, frame tracking and job classification.
// Depends on mfe_pkg.
module mfe_front
   import mfe_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_data,
   input  logic                   accept,
   input  logic [7:0]             payload_byte,
   input  logic [7:0]             message_id,
   input  logic [7:0]             payload_length,
   input  logic [7:0]             msg_seed,
   output job_type                job
);

   logic [7:0] system_id_ff, system_id_in;
   logic [7:0] component_id_ff, component_id_in;
   logic [7:0] seq_ff, seq_in;
   logic [7:0] remaining_ff, remaining_in;
   logic       open_ff, open_in;
   logic [7:0] extra_ff, extra_in;

   assign csr_ready = 1'b1;

   always_comb begin
      system_id_in    = system_id_ff;
      component_id_in = component_id_ff;
      if (csr_valid) begin
         if (csr_index == CSR_SYSTEM_ID) begin
            system_id_in = csr_data;
         end else if (csr_index == CSR_COMPONENT_ID) begin
            component_id_in = csr_data;
         end
      end
   end

   always_comb begin
      job.payload_byte    = payload_byte;
      job.message_id      = message_id;
      job.payload_length  = payload_length;
      job.msg_seed        = open_ff ? extra_ff : msg_seed;
      job.sequence_number = seq_ff;
      job.system_id       = system_id_ff;
      job.component_id    = component_id_ff;
      job.header          = !open_ff;
      seq_in              = seq_ff;
      remaining_in        = remaining_ff;
      open_in             = open_ff;
      extra_in            = extra_ff;
      if (open_ff) begin
         job.has_pay  = 1'b1;
         job.ends     = (remaining_ff == 8'd1);
         remaining_in = remaining_ff - 8'd1;
      end else begin
         job.has_pay  = (payload_length != 8'd0);
         job.ends     = (payload_length <= 8'd1);
         remaining_in = (payload_length == 8'd0) ? 8'd0 : payload_length - 8'd1;
      end
      if (accept) begin
         open_in = !job.ends;
         if (!open_ff) begin
            seq_in   = seq_ff + 8'd1;
            extra_in = msg_seed;
         end
      end else begin
         remaining_in = remaining_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         system_id_ff    <= 8'hFF;
         component_id_ff <= 8'h00;
         seq_ff          <= 8'h00;
         remaining_ff    <= 8'h00;
         open_ff         <= 1'b0;
         extra_ff        <= 8'h00;
      end else begin
         system_id_ff    <= system_id_in;
         component_id_ff <= component_id_in;
         seq_ff          <= seq_in;
         remaining_ff    <= remaining_in;
         open_ff         <= open_in;
         extra_ff        <= extra_in;
      end
   end

endmodule

// ===== hdl/mfe_queue.sv =====
// Short job queue between the front and the back end.
// Depends on mfe_pkg.
module mfe_queue
   import mfe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   job_type             mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in    = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = do_pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hdl/mfe_back.sv =====
// Back end: steps through the bytes of each job, keeps the CRC, holds the result register.
// Depends on mfe_pkg.
module mfe_back
   import mfe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       job_valid,
   input  job_type    job,
   output logic       job_pop,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_frame_byte,
   output logic       rsp_last_in_run,
   output logic       rsp_last_in_frame
);

   step_type    step_ff, step_in, cur_step, next_step;
   logic        started_ff, started_in;
   logic [15:0] crc_ff, crc_in, crc_x;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        run_ff, run_in;
   logic        frame_ff, frame_in;
   logic        advance, last_step;
   logic [7:0]  cur_byte;

   assign rsp_empty         = !out_valid_ff;
   assign rsp_frame_byte    = byte_ff;
   assign rsp_last_in_run   = run_ff;
   assign rsp_last_in_frame = frame_ff;

   assign advance  = job_valid && (!out_valid_ff || rsp_pop);
   assign cur_step = started_ff ? step_ff : (job.header ? ST_MARK : ST_PAY);
   assign crc_x    = crc_fold(crc_ff, job.msg_seed);

   always_comb begin
      next_step = ST_CRCH;
      cur_byte  = 8'h00;
      crc_in    = crc_ff;
      last_step = 1'b0;
      unique case (cur_step)
         ST_MARK: begin
            cur_byte  = START_MARKER;
            next_step = ST_LEN;
            crc_in    = CRC_SEED;
         end
         ST_LEN: begin
            cur_byte  = job.payload_length;
            next_step = ST_SEQ;
            crc_in    = crc_fold(crc_ff, cur_byte);
         end
         ST_SEQ: begin
            cur_byte  = job.sequence_number;
            next_step = ST_SYS;
            crc_in    = crc_fold(crc_ff, cur_byte);
         end
         ST_SYS: begin
            cur_byte  = job.system_id;
            next_step = ST_COMP;
            crc_in    = crc_fold(crc_ff, cur_byte);
         end
         ST_COMP: begin
            cur_byte  = job.component_id;
            next_step = ST_MID;
            crc_in    = crc_fold(crc_ff, cur_byte);
         end
         ST_MID: begin
            cur_byte  = job.message_id;
            next_step = job.has_pay ? ST_PAY : ST_CRCL;
            crc_in    = crc_fold(crc_ff, cur_byte);
         end
         ST_PAY: begin
            cur_byte  = job.payload_byte;
            next_step = ST_CRCL;
            last_step = !job.ends;
            crc_in    = crc_fold(crc_ff, cur_byte);
         end
         ST_CRCL: begin
            // fold the extra byte and show the low half in the same beat
            cur_byte  = crc_x[7:0];
            next_step = ST_CRCH;
            crc_in    = crc_x;
         end
         ST_CRCH: begin
            cur_byte  = crc_ff[15:8];
            last_step = 1'b1;
         end
         default: begin
            cur_byte = 8'h00;
         end
      endcase
   end

   always_comb begin
      job_pop      = advance && last_step;
      step_in      = step_ff;
      started_in   = started_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      byte_in      = byte_ff;
      run_in       = run_ff;
      frame_in     = frame_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         byte_in      = cur_byte;
         run_in       = last_step;
         frame_in     = (cur_step == ST_CRCH);
         started_in   = !last_step;
         step_in      = next_step;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         crc_ff <= crc_in;
      end
      byte_ff  <= byte_in;
      run_ff   <= run_in;
      frame_ff <= frame_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_MARK;
         started_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         started_ff   <= started_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ===== hdl/mavlink_v1_frame_encoder_top.sv =====
// MAVLink v1 transmit frame encoder, top level.
// Usage:
//   req_* is a queue input: an item is taken at a clock edge with req_push high and
//   req_full low. The first item of a frame samples message id, payload length and
//   CRC extra; it also carries the first payload byte unless the length is zero.
//   rsp_* is a queue output: while rsp_empty is low the oldest frame byte is shown
//   and rsp_pop takes it. rsp_last_in_run marks the last byte caused by an item,
//   rsp_last_in_frame the CRC high byte.
//   csr_* writes system id (index 0) and component id (index 1); csr_ready is
//   always high and other indexes are dropped.
// Timing:
//   An item taken into an empty queue passes from the queue to the result register.
//   The back end emits one byte per cycle while not stalled by the receiver: a payload
//   item yields its byte, a frame's first item adds the header bytes before it, the
//   closing item adds the CRC bytes, a zero-length frame is header and CRC alone. A
//   four-deep queue takes items back to back until it fills behind header and CRC bursts.
// Reset empties the queue and the result register and clears the sequence number and frame state.
// When the receiver stalls the result byte holds and req_full rises once the queue fills.
// Depends on mfe_pkg, mfe_front, mfe_queue, mfe_back.
module mavlink_v1_frame_encoder_top
   import mfe_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [7:0]             req_payload_byte,
   input  logic [7:0]             req_message_id,
   input  logic [7:0]             req_payload_length,
   input  logic [7:0]             req_msg_seed,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [7:0]             rsp_frame_byte,
   output logic                   rsp_last_in_run,
   output logic                   rsp_last_in_frame,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_data
);

   job_type front_job, head_job;
   logic    accept, head_valid, job_pop;

   assign accept = req_push && !req_full;

   mfe_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .accept         (accept),
      .payload_byte   (req_payload_byte),
      .message_id     (req_message_id),
      .payload_length (req_payload_length),
      .msg_seed       (req_msg_seed),
      .job            (front_job)
   );

   mfe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .push_job   (front_job),
      .full       (req_full),
      .pop        (job_pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   mfe_back u_back (
      .clock             (clock),
      .reset             (reset),
      .job_valid         (head_valid),
      .job               (head_job),
      .job_pop           (job_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_last_in_run   (rsp_last_in_run),
      .rsp_last_in_frame (rsp_last_in_frame)
   );

endmodule
